FILE: hdl/wgha_pkg.sv
// ----------------------------------------------------------------------------
// wgha_pkg
// shared constants, codes and helpers for the weighted grid heatmap accumulator
// ----------------------------------------------------------------------------
package wgha_pkg;

	// grid store geometry
	localparam int MAX_COLS   = 16;
	localparam int MAX_ROWS   = 16;
	localparam int SCORE_BITS = 24;
	localparam int NUM_CELLS  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W     = $clog2(NUM_CELLS);

	// port field widths
	localparam int POS_W       = 12;
	localparam int SPAN_W      = 12;
	localparam int GRID_W      = 5;
	localparam int CFG_DATA_W  = 12;
	localparam int CFG_IDX_W   = 2;
	localparam int CMD_W       = 2;
	localparam int SEV_W       = 2;
	localparam int SEL_W       = 4;
	localparam int OUT_SCORE_W = 24;
	localparam int FRAME_W     = 32;
	localparam int LEVEL_W     = 8;

	// bin widths
	localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
	localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
	localparam int BIN_STEPS_C = ($clog2(MAX_COLS) > $clog2(MAX_ROWS)) ?
		$clog2(MAX_COLS) : $clog2(MAX_ROWS);
	localparam int BIN_STEPS = (BIN_STEPS_C > 1) ? BIN_STEPS_C : 1;

	// normalisation in q1.10
	localparam int Q_FRAC     = 10;
	localparam int NORM_STEPS = Q_FRAC;
	localparam int Q_ONE      = 1 << Q_FRAC;
	localparam int Q_HALF     = 1 << (Q_FRAC - 1);
	localparam int QUO_W      = Q_FRAC + 1;

	// shared divider datapath
	localparam int BIN_DIV_W = SPAN_W + BIN_STEPS - 1;
	localparam int DIV_W     = (BIN_DIV_W > SCORE_BITS) ? BIN_DIV_W : SCORE_BITS;
	localparam int REM_W     = DIV_W + 1;
	localparam int STEP_W    = $clog2(NORM_STEPS + 1);

	// colour and flag constants
	localparam int RED_SLOPE   = 510;
	localparam int GREEN_SLOPE = 400;
	localparam int RED_MAX     = 255;
	localparam int GREEN_MAX   = 200;
	localparam int ROUND_HALF  = 512;
	localparam int PCT_SCALE   = 100;
	localparam int LABEL_PCT   = 15;

	localparam logic [SCORE_BITS-1:0] SCORE_SAT = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 2'd0,
		CMD_FRAME = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_GRID_COLUMNS = 2'd2,
		REG_GRID_ROWS    = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_COL_LOAD,
		S_COL_DIV,
		S_ROW_LOAD,
		S_ROW_DIV,
		S_RD_ADDR,
		S_RD_DATA,
		S_NORM_LOAD,
		S_NORM_DIV,
		S_FINISH
	} state_t;

	function automatic logic [SCORE_BITS-1:0] sev_weight(input logic [SEV_W-1:0] sev);
		logic [SCORE_BITS-1:0] w;
		case (sev)
			2'd0:    w = SCORE_BITS'(0);
			2'd1:    w = SCORE_BITS'(1);
			2'd2:    w = SCORE_BITS'(3);
			default: w = SCORE_BITS'(7);
		endcase
		return w;
	endfunction

endpackage

FILE: hdl/wgha_ram.sv
// ----------------------------------------------------------------------------
// wgha_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module wgha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: hdl/weighted_grid_heatmap_accumulator.sv
// ----------------------------------------------------------------------------
// weighted_grid_heatmap_accumulator
// one item at a time; a new transfer is taken the cycle after the result is
// registered, and adds and reads are paced by the shared restoring divider
// (4 steps per bin, 10 steps for the q1.10 ratio)
// async reset restores the default geometry, zeroes peak and frame count and
// marks every cell empty through per-cell valid bits; no clearing pass
// ----------------------------------------------------------------------------
module weighted_grid_heatmap_accumulator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wgha_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wgha_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [wgha_pkg::CMD_W-1:0]        cmd,
	input  logic [wgha_pkg::POS_W-1:0]        pos_x,
	input  logic [wgha_pkg::POS_W-1:0]        pos_y,
	input  logic [wgha_pkg::SEV_W-1:0]        severity,
	input  logic [wgha_pkg::SEL_W-1:0]        read_row,
	input  logic [wgha_pkg::SEL_W-1:0]        read_col,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [wgha_pkg::OUT_SCORE_W-1:0]  cell_score,
	output logic [wgha_pkg::OUT_SCORE_W-1:0]  max_score,
	output logic [wgha_pkg::FRAME_W-1:0]      frames_seen,
	output logic [wgha_pkg::LEVEL_W-1:0]      red_level,
	output logic [wgha_pkg::LEVEL_W-1:0]      green_level,
	output logic                              shown,
	output logic                              labelled
);

	import wgha_pkg::*;

	localparam int XPROD_W = POS_W + COL_CNT_W;
	localparam int YPROD_W = POS_W + ROW_CNT_W;
	localparam int FLAG_W  = SCORE_BITS + 7;
	localparam int COLOR_W = QUO_W + 10;

	// configuration
	logic [SPAN_W-1:0] frame_width_q;
	logic [SPAN_W-1:0] frame_height_q;
	logic [GRID_W-1:0] grid_columns_q;
	logic [GRID_W-1:0] grid_rows_q;

	// item held during processing
	cmd_t             cmd_q;
	logic [POS_W-1:0] pos_x_q;
	logic [POS_W-1:0] pos_y_q;
	logic [SEV_W-1:0] sev_q;
	logic [SEL_W-1:0] read_row_q;
	logic [SEL_W-1:0] read_col_q;

	state_t state_q;
	state_t state_d;

	// shared divider
	logic [REM_W-1:0]  rem_q;
	logic [DIV_W-1:0]  div_q;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              step_ge;
	logic [REM_W-1:0]  step_diff;
	logic [REM_W-1:0]  rem_next;
	logic [QUO_W-1:0]  quo_next;

	// grid state
	logic [COL_W-1:0]      col_q;
	logic [ADDR_W-1:0]     addr_q;
	logic                  rd_ok_q;
	logic [NUM_CELLS-1:0]  valid_q;
	logic [SCORE_BITS-1:0] score_q;
	logic [SCORE_BITS-1:0] peak_q;
	logic [FRAME_W-1:0]    frames_q;
	logic                  shown_calc_q;
	logic                  labelled_calc_q;

	// outputs
	logic                   out_valid_q;
	logic [OUT_SCORE_W-1:0] cell_score_q;
	logic [OUT_SCORE_W-1:0] max_score_q;
	logic [FRAME_W-1:0]     frames_seen_q;
	logic [LEVEL_W-1:0]     red_level_q;
	logic [LEVEL_W-1:0]     green_level_q;
	logic                   shown_q;
	logic                   labelled_q;

	// control
	logic in_xfer;
	logic out_free;
	logic out_load;
	logic ram_rd_en;
	logic ram_wr_en;

	// combinational datapath
	logic [COL_CNT_W-1:0]  cols;
	logic [ROW_CNT_W-1:0]  rows;
	logic [COL_W-1:0]      cols_last;
	logic [ROW_W-1:0]      rows_last;
	logic [XPROD_W-1:0]    x_prod;
	logic [YPROD_W-1:0]    y_prod;
	logic                  x_beyond;
	logic                  y_beyond;
	logic                  in_store;
	logic [ADDR_W-1:0]     ram_addr;
	logic [SCORE_BITS-1:0] ram_rdata;
	logic [SCORE_BITS-1:0] cur_score;
	logic [SCORE_BITS:0]   score_sum;
	logic [SCORE_BITS-1:0] new_score;
	logic [FLAG_W-1:0]     score_x100;
	logic [FLAG_W-1:0]     peak_x15;
	logic                  is_cell;
	logic [COLOR_W-1:0]    red_full;
	logic [COLOR_W-1:0]    green_full;
	logic [LEVEL_W-1:0]    red_val;
	logic [LEVEL_W-1:0]    green_val;

	assign cfg_ready   = 1'b1;
	assign in_xfer     = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign cell_score  = cell_score_q;
	assign max_score   = max_score_q;
	assign frames_seen = frames_seen_q;
	assign red_level   = red_level_q;
	assign green_level = green_level_q;
	assign shown       = shown_q;
	assign labelled    = labelled_q;

	// grid size clamped to the store
	always_comb begin
		if (grid_columns_q == '0) begin
			cols = COL_CNT_W'(1);
		end else if (int'(grid_columns_q) > MAX_COLS) begin
			cols = COL_CNT_W'(MAX_COLS);
		end else begin
			cols = COL_CNT_W'(grid_columns_q);
		end
		if (grid_rows_q == '0) begin
			rows = ROW_CNT_W'(1);
		end else if (int'(grid_rows_q) > MAX_ROWS) begin
			rows = ROW_CNT_W'(MAX_ROWS);
		end else begin
			rows = ROW_CNT_W'(grid_rows_q);
		end
	end

	assign cols_last = COL_W'(cols - COL_CNT_W'(1));
	assign rows_last = ROW_W'(rows - ROW_CNT_W'(1));
	assign x_prod    = XPROD_W'(pos_x_q) * XPROD_W'(cols);
	assign y_prod    = YPROD_W'(pos_y_q) * YPROD_W'(rows);
	// beyond the frame (or zero span) lands in the last bin
	assign x_beyond  = pos_x_q >= frame_width_q;
	assign y_beyond  = pos_y_q >= frame_height_q;

	// restoring divide step
	assign step_ge   = rem_q >= REM_W'(div_q);
	assign step_diff = step_ge ? (rem_q - REM_W'(div_q)) : rem_q;
	assign rem_next  = step_diff << 1;
	assign quo_next  = {quo_q[QUO_W-2:0], step_ge};

	assign in_store = (int'(read_row_q) < MAX_ROWS) && (int'(read_col_q) < MAX_COLS);

	always_comb begin
		if (cmd_q == CMD_READ) begin
			ram_addr = ADDR_W'(ADDR_W'(read_row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(read_col_q));
		end else begin
			ram_addr = ADDR_W'(ADDR_W'(quo_q[ROW_W-1:0]) * ADDR_W'(MAX_COLS)
				+ ADDR_W'(col_q));
		end
	end

	assign cur_score = rd_ok_q ? ram_rdata : '0;
	assign score_sum = {1'b0, cur_score} + {1'b0, sev_weight(sev_q)};
	assign new_score = score_sum[SCORE_BITS] ? SCORE_SAT : score_sum[SCORE_BITS-1:0];

	assign score_x100 = FLAG_W'(score_q) * FLAG_W'(PCT_SCALE);
	assign peak_x15   = FLAG_W'(peak_q) * FLAG_W'(LABEL_PCT);

	assign is_cell = (cmd_q == CMD_ADD) || (cmd_q == CMD_READ);

	// colour from q1.10 ratio, rounded half up
	assign red_full   = COLOR_W'(quo_q) * COLOR_W'(RED_SLOPE) + COLOR_W'(ROUND_HALF);
	assign green_full = (COLOR_W'(Q_ONE) - COLOR_W'(quo_q)) * COLOR_W'(GREEN_SLOPE)
		+ COLOR_W'(ROUND_HALF);

	always_comb begin
		if (int'(quo_q) < Q_HALF) begin
			red_val   = LEVEL_W'(red_full >> Q_FRAC);
			green_val = LEVEL_W'(GREEN_MAX);
		end else begin
			red_val   = LEVEL_W'(RED_MAX);
			green_val = LEVEL_W'(green_full >> Q_FRAC);
		end
	end

	wgha_ram #(
		.WIDTH(SCORE_BITS),
		.DEPTH(NUM_CELLS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (addr_q),
		.wr_data (new_score),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_addr),
		.rd_data (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (cmd_t'(cmd))
						CMD_ADD:  state_d = S_COL_LOAD;
						CMD_READ: state_d = S_RD_ADDR;
						default:  state_d = S_FINISH;
					endcase
				end
			end
			S_COL_LOAD:  state_d = x_beyond ? S_ROW_LOAD : S_COL_DIV;
			S_COL_DIV:   state_d = (step_q == STEP_W'(1)) ? S_ROW_LOAD : S_COL_DIV;
			S_ROW_LOAD:  state_d = y_beyond ? S_RD_ADDR : S_ROW_DIV;
			S_ROW_DIV:   state_d = (step_q == STEP_W'(1)) ? S_RD_ADDR : S_ROW_DIV;
			S_RD_ADDR:   state_d = S_RD_DATA;
			S_RD_DATA:   state_d = S_NORM_LOAD;
			S_NORM_LOAD: state_d = (peak_q == '0 || score_q >= peak_q) ? S_FINISH : S_NORM_DIV;
			S_NORM_DIV:  state_d = (step_q == STEP_W'(1)) ? S_FINISH : S_NORM_DIV;
			S_FINISH:    state_d = out_free ? S_IDLE : S_FINISH;
			default:     state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall  = 1'b1;
		ram_rd_en = 1'b0;
		ram_wr_en = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE:    in_stall  = 1'b0;
			S_RD_ADDR: ram_rd_en = 1'b1;
			S_RD_DATA: ram_wr_en = (cmd_q == CMD_ADD);
			S_FINISH:  out_load  = out_free;
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			frame_width_q  <= SPAN_W'(640);
			frame_height_q <= SPAN_W'(480);
			grid_columns_q <= GRID_W'(16);
			grid_rows_q    <= GRID_W'(12);
			valid_q        <= '0;
			peak_q         <= '0;
			frames_q       <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[SPAN_W-1:0];
					REG_FRAME_HEIGHT: frame_height_q <= cfg_data[SPAN_W-1:0];
					REG_GRID_COLUMNS: grid_columns_q <= cfg_data[GRID_W-1:0];
					REG_GRID_ROWS:    grid_rows_q    <= cfg_data[GRID_W-1:0];
					default: begin
					end
				endcase
			end
			if (in_xfer) begin
				case (cmd_t'(cmd))
					CMD_FRAME: frames_q <= frames_q + FRAME_W'(1);
					CMD_CLEAR: begin
						frames_q <= '0;
						peak_q   <= '0;
						valid_q  <= '0;
					end
					default: begin
					end
				endcase
			end
			if (ram_wr_en) begin
				valid_q[addr_q] <= 1'b1;
				if (new_score > peak_q) begin
					peak_q <= new_score;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_q      <= cmd_t'(cmd);
					pos_x_q    <= pos_x;
					pos_y_q    <= pos_y;
					sev_q      <= severity;
					read_row_q <= read_row;
					read_col_q <= read_col;
				end
			end
			S_COL_LOAD: begin
				div_q  <= DIV_W'(frame_width_q) << (BIN_STEPS - 1);
				rem_q  <= REM_W'(x_prod);
				step_q <= STEP_W'(BIN_STEPS);
				quo_q  <= x_beyond ? QUO_W'(cols_last) : '0;
			end
			S_ROW_LOAD: begin
				col_q  <= quo_q[COL_W-1:0];
				div_q  <= DIV_W'(frame_height_q) << (BIN_STEPS - 1);
				rem_q  <= REM_W'(y_prod);
				step_q <= STEP_W'(BIN_STEPS);
				quo_q  <= y_beyond ? QUO_W'(rows_last) : '0;
			end
			S_COL_DIV, S_ROW_DIV, S_NORM_DIV: begin
				rem_q  <= rem_next;
				quo_q  <= quo_next;
				step_q <= step_q - STEP_W'(1);
			end
			S_RD_ADDR: begin
				addr_q  <= ram_addr;
				rd_ok_q <= valid_q[ram_addr] && ((cmd_q == CMD_ADD) || in_store);
			end
			S_RD_DATA: begin
				score_q <= (cmd_q == CMD_ADD) ? new_score : cur_score;
			end
			S_NORM_LOAD: begin
				shown_calc_q    <= (peak_q != '0) && (score_x100 >= FLAG_W'(peak_q));
				labelled_calc_q <= (peak_q != '0) && (score_x100 > peak_x15);
				div_q           <= DIV_W'(peak_q);
				rem_q           <= REM_W'(score_q) << 1;
				step_q          <= STEP_W'(NORM_STEPS);
				if (peak_q != '0 && score_q >= peak_q) begin
					quo_q <= QUO_W'(Q_ONE);
				end else begin
					quo_q <= '0;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					max_score_q   <= OUT_SCORE_W'(peak_q);
					frames_seen_q <= frames_q;
					if (is_cell) begin
						cell_score_q  <= OUT_SCORE_W'(score_q);
						red_level_q   <= red_val;
						green_level_q <= green_val;
						shown_q       <= shown_calc_q;
						labelled_q    <= labelled_calc_q;
					end else begin
						cell_score_q  <= '0;
						red_level_q   <= '0;
						green_level_q <= '0;
						shown_q       <= 1'b0;
						labelled_q    <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hdl/wgha_checker.sv
// ----------------------------------------------------------------------------
// wgha_checker
// port-level checks on the heatmap accumulator, bound to the top level
// ----------------------------------------------------------------------------
module wgha_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [wgha_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [wgha_pkg::CFG_DATA_W-1:0]   cfg_data,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [wgha_pkg::CMD_W-1:0]        cmd,
	input logic [wgha_pkg::POS_W-1:0]        pos_x,
	input logic [wgha_pkg::POS_W-1:0]        pos_y,
	input logic [wgha_pkg::SEV_W-1:0]        severity,
	input logic [wgha_pkg::SEL_W-1:0]        read_row,
	input logic [wgha_pkg::SEL_W-1:0]        read_col,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [wgha_pkg::OUT_SCORE_W-1:0]  cell_score,
	input logic [wgha_pkg::OUT_SCORE_W-1:0]  max_score,
	input logic [wgha_pkg::FRAME_W-1:0]      frames_seen,
	input logic [wgha_pkg::LEVEL_W-1:0]      red_level,
	input logic [wgha_pkg::LEVEL_W-1:0]      green_level,
	input logic                              shown,
	input logic                              labelled
);

	import wgha_pkg::*;

	// busy in the cycle after an input transfer
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken in back-to-back cycles");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cell_score) && $stable(max_score)
			&& $stable(frames_seen))
		else $error("stalled result changed");

	a_label_shown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && labelled |-> shown)
		else $error("labelled cell not shown");

	a_shown_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shown |-> max_score != '0)
		else $error("shown with zero maximum");

	// end of frame and clear carry no colour
	a_colour_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && red_level != LEVEL_W'(RED_MAX) |->
			green_level == LEVEL_W'(GREEN_MAX) || (red_level == '0 && green_level == '0))
		else $error("colour off the green-to-red ramp");

endmodule

bind weighted_grid_heatmap_accumulator wgha_checker u_wgha_checker (.*);
